// ----- hw/rtl/tss_pkg.sv -----
// Package for the timed step sequencer.
// Field widths, request codes, the control struct shared by the core and top level.
// No dependencies.
package tss_pkg;

    localparam int DEFAULT_MAX_STEPS = 16;

    localparam int REQ_W     = 2;
    localparam int IDX_W     = 4;
    localparam int DUR_W     = 16;
    localparam int VAL_W     = 16;
    localparam int LOOP_W    = 16;
    localparam int LEN_W     = 5;
    localparam int ELAPSED_W = 17;
    localparam int ENTRY_W   = DUR_W + VAL_W;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [LEN_W-1:0]     LEN_RESET   = LEN_W'(1);

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd3;

    // Per-transaction control from the step core
    typedef struct packed {
        logic ram_we;
        logic running;
        logic changed;
    } tss_ctrl_t;

endpackage

// ----- hw/rtl/tss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/tss_step.sv -----
// Next-state logic of the sequencer for one transaction.
// Uses tss_pkg; purely combinational, registers live in the top level.
module tss_step
    import tss_pkg::*;
#(
    parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
    input  logic [REQ_W-1:0]                            req_type,
    input  logic [IDX_W-1:0]                            entry_index,
    input  logic [LOOP_W-1:0]                           loop_count,
    input  logic [LEN_W-1:0]                            sequence_length,
    input  logic [DUR_W-1:0]                            cur_duration,
    input  logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1)-1:0] position,
    input  logic [ELAPSED_W-1:0]                        elapsed,
    input  logic [LOOP_W-1:0]                           loops_left,
    input  logic                                        active,
    input  logic [$clog2(MAX_STEPS + 1)-1:0]            reported,
    output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1)-1:0] position_next,
    output logic [ELAPSED_W-1:0]                        elapsed_next,
    output logic [LOOP_W-1:0]                           loops_left_next,
    output logic                                        active_next,
    output logic [$clog2(MAX_STEPS + 1)-1:0]            reported_next,
    output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1)-1:0] wr_addr,
    output tss_ctrl_t                                   ctrl
);

    localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = PW + 1;
    localparam int RW = $clog2(MAX_STEPS + 1);
    localparam logic [RW-1:0] NO_POSITION = RW'(MAX_STEPS);

    logic [CW-1:0]        eff_len;
    logic [CW-1:0]        pos_inc;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] dur_ext;
    logic [RW-1:0]        rep_mid;
    logic [RW-1:0]        pos_ext;
    logic                 index_ok;

    // Length of 0 behaves as 1, anything above the table size is clamped
    always_comb
    begin
        if (sequence_length == '0)
        begin
            eff_len = CW'(1);
        end
        else if (32'(sequence_length) > MAX_STEPS)
        begin
            eff_len = CW'(MAX_STEPS);
        end
        else
        begin
            eff_len = CW'(sequence_length);
        end
    end

    assign pos_inc     = {1'b0, position} + CW'(1);
    assign elapsed_inc = (elapsed != ELAPSED_MAX) ? elapsed + ELAPSED_W'(1) : elapsed;
    assign dur_ext     = ELAPSED_W'(cur_duration);
    assign index_ok    = 32'(entry_index) < MAX_STEPS;
    assign wr_addr     = PW'(entry_index);

    always_comb
    begin
        position_next   = position;
        elapsed_next    = elapsed;
        loops_left_next = loops_left;
        active_next     = active;
        rep_mid         = reported;
        ctrl            = '0;

        case (req_type)
            REQ_TICK:
            begin
                if (active)
                begin
                    ctrl.running = 1'b1;
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= dur_ext)
                    begin
                        elapsed_next = elapsed_inc - dur_ext;
                        if (pos_inc < eff_len)
                        begin
                            position_next = PW'(pos_inc);
                        end
                        else
                        begin
                            position_next = '0;
                            if (loops_left == LOOP_W'(1))
                            begin
                                // last loop done: halt, the result still says running
                                elapsed_next    = '0;
                                loops_left_next = '0;
                                active_next     = 1'b0;
                                rep_mid         = '0;
                            end
                            else if (loops_left != '0)
                            begin
                                loops_left_next = loops_left - LOOP_W'(1);
                            end
                        end
                    end
                end
            end
            REQ_START:
            begin
                loops_left_next = loop_count;
                position_next   = '0;
                elapsed_next    = '0;
                rep_mid         = NO_POSITION;
                active_next     = 1'b1;
                ctrl.running    = 1'b1;
            end
            REQ_STOP:
            begin
                position_next   = '0;
                elapsed_next    = '0;
                loops_left_next = '0;
                active_next     = 1'b0;
                rep_mid         = '0;
            end
            REQ_WRITE:
            begin
                ctrl.ram_we  = index_ok;
                ctrl.running = active;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase

        // position moved away from the one last reported
        ctrl.changed = (RW'(position_next) != rep_mid);
    end

    assign pos_ext       = RW'(position_next);
    assign reported_next = (pos_ext != rep_mid) ? pos_ext : rep_mid;

endmodule

// ----- hw/rtl/timed_step_sequencer.sv -----
// Timed step sequencer: steps through a table of (duration, value) entries per tick.
// A transaction passes the input register, then the registered state and result stage.
// Throughput: one transaction per cycle, one table read each, unless out_stall backs up.
// The table RAM is read at the post-transaction position; same-cycle writes are forwarded.
// Reset (rst_n low, async): sequencer stopped, length 1, both pipeline stages empty;
// the step table is not cleared and holds garbage until written.
module timed_step_sequencer
    import tss_pkg::*;
#(
    parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration: sequence length
    input  logic                     cfg_wr_en,
    input  logic [LEN_W-1:0]         cfg_wr_data,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic [DUR_W-1:0]         entry_duration,
    input  logic signed [VAL_W-1:0]  entry_value,
    input  logic [LOOP_W-1:0]        loop_count,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     running,
    output logic signed [VAL_W-1:0]  current_value,
    output logic                     new_value
);

    localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int RW = $clog2(MAX_STEPS + 1);

    // Input register stage
    logic              in_valid_reg;
    logic [REQ_W-1:0]  req_type_reg;
    logic [IDX_W-1:0]  entry_index_reg;
    logic [DUR_W-1:0]  entry_duration_reg;
    logic [VAL_W-1:0]  entry_value_reg;
    logic [LOOP_W-1:0] loop_count_reg;

    // Sequencer state
    logic [LEN_W-1:0]     seq_len_reg;
    logic [PW-1:0]        position_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [LOOP_W-1:0]    loops_left_reg;
    logic                 active_reg;
    logic [RW-1:0]        reported_reg;

    logic [PW-1:0]        position_next;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [LOOP_W-1:0]    loops_left_next;
    logic                 active_next;
    logic [RW-1:0]        reported_next;
    logic [PW-1:0]        wr_addr;
    tss_ctrl_t            ctrl;

    // Result stage; the RAM read data register is part of it
    logic               out_valid_reg;
    logic               running_reg;
    logic               new_value_reg;
    logic               fwd_sel_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] cur_entry;

    logic process;

    // A transaction leaves the input register when the result register is free
    // or being emptied in the same cycle.
    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_type_reg       <= req_type;
            entry_index_reg    <= entry_index;
            entry_duration_reg <= entry_duration;
            entry_value_reg    <= entry_value;
            loop_count_reg     <= loop_count;
        end
    end

    // Entry at the current position: RAM data from the last read, or the
    // write data if the read and a write hit the same step on that edge.
    assign cur_entry = fwd_sel_reg ? fwd_data_reg : ram_rdata;

    tss_step #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step (
        .req_type        (req_type_reg),
        .entry_index     (entry_index_reg),
        .loop_count      (loop_count_reg),
        .sequence_length (seq_len_reg),
        .cur_duration    (cur_entry[ENTRY_W-1:VAL_W]),
        .position        (position_reg),
        .elapsed         (elapsed_reg),
        .loops_left      (loops_left_reg),
        .active          (active_reg),
        .reported        (reported_reg),
        .position_next   (position_next),
        .elapsed_next    (elapsed_next),
        .loops_left_next (loops_left_next),
        .active_next     (active_next),
        .reported_next   (reported_next),
        .wr_addr         (wr_addr),
        .ctrl            (ctrl)
    );

    // Step table: duration in the upper half, value in the lower half.
    // Read at the post-transaction position so the result value and the
    // next tick's duration both come out of the same registered read.
    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (process && ctrl.ram_we),
        .waddr (wr_addr),
        .wdata ({entry_duration_reg, entry_value_reg}),
        .re    (process),
        .raddr (position_next),
        .rdata (ram_rdata)
    );

    // Sequencer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg    <= LEN_RESET;
            position_reg   <= '0;
            elapsed_reg    <= '0;
            loops_left_reg <= '0;
            active_reg     <= 1'b0;
            reported_reg   <= '0;
            fwd_sel_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seq_len_reg <= cfg_wr_data;
            end
            if (process)
            begin
                position_reg   <= position_next;
                elapsed_reg    <= elapsed_next;
                loops_left_reg <= loops_left_next;
                active_reg     <= active_next;
                reported_reg   <= reported_next;
                fwd_sel_reg    <= ctrl.ram_we && (wr_addr == position_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            fwd_data_reg <= {entry_duration_reg, entry_value_reg};
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            new_value_reg <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= ctrl.running;
                // position moved away from the one last reported
                new_value_reg <= ctrl.changed;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign running       = running_reg;
    assign new_value     = new_value_reg;
    assign current_value = running_reg ? cur_entry[VAL_W-1:0] : '0;

endmodule

// ----- sim/sequencer_checker.sv -----
// Scoreboard for the timed step sequencer: mirrors the step table and run state,
// predicts one report per request transaction and compares it with the result channel.
// Depends on tss_pkg for widths and request codes.
module sequencer_checker
    import tss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [LEN_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic [DUR_W-1:0]        entry_duration,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic [LOOP_W-1:0]       loop_count,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    running,
    input  logic signed [VAL_W-1:0] current_value,
    input  logic                    new_value,
    output int                      mismatches,
    output int                      waiting,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = DEFAULT_MAX_STEPS;

    typedef struct packed {
        logic                    running;
        logic signed [VAL_W-1:0] level;
        logic                    moved;
    } step_report_t;

    // mirrored sequencer state
    logic [DUR_W-1:0]        durations [STEPS];
    logic signed [VAL_W-1:0] levels [STEPS];
    logic [IDX_W-1:0]        pos;
    logic [ELAPSED_W-1:0]    elapsed;
    logic [LOOP_W-1:0]       loops_left;
    logic                    active;
    logic [LEN_W-1:0]        last_pos;    // position at previous report, STEPS = none yet
    logic [LEN_W-1:0]        length_reg;

    step_report_t expected_reports[$];

    task automatic clear_run();
        pos        = '0;
        elapsed    = '0;
        loops_left = '0;
        active     = 1'b0;
        last_pos   = '0;
    endtask

    task automatic advance_sequencer(
        input  logic [REQ_W-1:0]        req,
        input  logic [IDX_W-1:0]        idx,
        input  logic [DUR_W-1:0]        dur,
        input  logic signed [VAL_W-1:0] val,
        input  logic [LOOP_W-1:0]       loops,
        output step_report_t            rpt
    );
        int span;
        rpt  = '0;
        span = (length_reg == '0) ? 1 :
               (int'(length_reg) > STEPS) ? STEPS : int'(length_reg);
        case (req)
            REQ_TICK:
            begin
                if (active)
                begin
                    if (elapsed != ELAPSED_MAX)
                        elapsed = elapsed + 1'b1;
                    // duration is read live, so a rewrite of the current step counts now
                    if (elapsed >= ELAPSED_W'(durations[pos]))
                    begin
                        elapsed = elapsed - ELAPSED_W'(durations[pos]);
                        if (int'(pos) + 1 < span)
                            pos = pos + 1'b1;
                        else
                        begin
                            pos = '0;
                            if (loops_left == LOOP_W'(1))
                                clear_run();
                            else if (loops_left != '0)
                                loops_left = loops_left - 1'b1;
                        end
                    end
                    // the tick ending the final loop still reports running
                    rpt.running = 1'b1;
                    rpt.level   = levels[pos];
                end
            end
            REQ_START:
            begin
                loops_left  = loops;
                pos         = '0;
                elapsed     = '0;
                last_pos    = LEN_W'(STEPS);
                active      = 1'b1;
                rpt.running = 1'b1;
                rpt.level   = levels[0];
            end
            REQ_STOP:
                clear_run();
            REQ_WRITE:
            begin
                durations[idx] = dur;
                levels[idx]    = val;
                if (active)
                begin
                    rpt.running = 1'b1;
                    rpt.level   = levels[pos];
                end
            end
        endcase
        rpt.moved = (LEN_W'(pos) != last_pos);
        if (rpt.moved)
            last_pos = LEN_W'(pos);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result %0d, %s: got %0d, expected %0d",
                 $time, checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_report_t fresh;
        step_report_t want;
        if (!rst_n)
        begin
            expected_reports.delete();
            clear_run();
            length_reg = LEN_RESET;
            mismatches = 0;
            checked    = 0;
            waiting    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_sequencer(req_type, entry_index, entry_duration, entry_value,
                                  loop_count, fresh);
                expected_reports.push_back(fresh);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("result with nothing pending", 1, 0);
                else
                begin
                    want = expected_reports.pop_front();
                    if (running !== want.running)
                        report_mismatch("running", int'(running), int'(want.running));
                    if (current_value !== want.level)
                        report_mismatch("current_value", int'(current_value),
                                        int'(want.level));
                    if (new_value !== want.moved)
                        report_mismatch("new_value", int'(new_value), int'(want.moved));
                end
                checked++;
            end
            if (cfg_wr_en)
                length_reg = cfg_wr_data;
            waiting = expected_reports.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the timed step sequencer testbench: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on tss_pkg, the RTL top
// timed_step_sequencer and sequencer_checker.
module testbench;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = DEFAULT_MAX_STEPS;
    localparam int IDLE_PCT    = 27;      // chance of a bubble per cycle on each side
    localparam int HOLD_CYCLES = 60;      // one long result-side hold-off
    localparam int QUIET_LIMIT = 3000;    // cycles without any transaction
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 48;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [LEN_W-1:0]        cfg_wr_data    = '0;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic [REQ_W-1:0]        req_type       = REQ_TICK;
    logic [IDX_W-1:0]        entry_index    = '0;
    logic [DUR_W-1:0]        entry_duration = '0;
    logic signed [VAL_W-1:0] entry_value    = '0;
    logic [LOOP_W-1:0]       loop_count     = '0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic                    running;
    logic signed [VAL_W-1:0] current_value;
    logic                    new_value;

    int mismatches;
    int waiting;
    int checked;

    // stimulus bookkeeping
    logic [STEPS-1:0] filled = '0;   // table entries written at least once
    bit  sender_calm = 1'b0;         // sender offers back to back
    logic rx_calm    = 1'b0;         // receiver never stalls on its own
    int  squeeze_req = 0;            // bumped to ask the receiver for one long hold-off
    int  squeeze_ack = 0;
    int  hold_left   = 0;
    int  quiet       = 0;
    int  n_tick = 0, n_start = 0, n_stop = 0, n_write = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    timed_step_sequencer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_duration (entry_duration),
        .entry_value    (entry_value),
        .loop_count     (loop_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running        (running),
        .current_value  (current_value),
        .new_value      (new_value)
    );

    sequencer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_duration (entry_duration),
        .entry_value    (entry_value),
        .loop_count     (loop_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running        (running),
        .current_value  (current_value),
        .new_value      (new_value),
        .mismatches     (mismatches),
        .waiting        (waiting),
        .checked        (checked)
    );

    // Result side: random stalls, except during the requested hold-off, which is
    // counted here so the sender keeps pushing until the pipeline backs up.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (squeeze_req != squeeze_ack)
        begin
            out_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            squeeze_ack <= squeeze_req;
        end
        else
            out_stall <= !rx_calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: any accepted transaction on either channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet, waiting);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // One request transaction. Bubbles go in front of it; valid stays high into
    // the next request so nothing is lowered and raised in the same step.
    task automatic send_request(
        input logic [REQ_W-1:0]  kind,
        input logic [IDX_W-1:0]  idx,
        input logic [DUR_W-1:0]  dur,
        input logic [VAL_W-1:0]  val,
        input logic [LOOP_W-1:0] loops
    );
        while (!sender_calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        entry_index    <= idx;
        entry_duration <= dur;
        entry_value    <= val;
        loop_count     <= loops;
        do
            @(posedge clk);
        while (in_stall);
        case (kind)
            REQ_TICK:  n_tick++;
            REQ_START: n_start++;
            REQ_STOP:  n_stop++;
            REQ_WRITE:
            begin
                n_write++;
                filled[idx] = 1'b1;
            end
        endcase
    endtask

    // Ticks, starts and stops carry random junk in the fields they ignore.
    task automatic send_bare(input logic [REQ_W-1:0] kind, input logic [LOOP_W-1:0] loops);
        send_request(kind, IDX_W'($urandom), DUR_W'($urandom), VAL_W'($urandom), loops);
    endtask

    // Mostly short steps so sequences wrap and finish; now and then a long one.
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DUR_W'($urandom_range(0, 3));
        else if (r < 85)
            return DUR_W'($urandom_range(4, 12));
        return DUR_W'($urandom);
    endfunction

    function automatic logic [LOOP_W-1:0] pick_loops();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return LOOP_W'($urandom_range(1, 3));
        else if (r < 65)
            return '0;
        return LOOP_W'($urandom);
    endfunction

    // Drop valid after the last transaction, then wait for every result.
    // Returns on a rising edge so the next drive lands there.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        @(posedge clk);
    endtask

    // Only called with nothing in flight.
    task automatic set_length(input logic [LEN_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random phase at a given length. The sequencer may still be running from
    // the previous phase, which covers a length change under a live position.
    task automatic run_phase(input logic [LEN_W-1:0] len, input bit squeeze, input bit calm);
        int span;
        int made;
        int r;
        logic [IDX_W-1:0] idx;
        settle();
        set_length(len);
        span = (len == '0) ? 1 : (int'(len) > STEPS) ? STEPS : int'(len);
        made = 0;
        if (calm)
            sender_calm = 1'b1;
        // every step that can become current must hold a defined entry first
        for (int i = 0; i < span; i++)
        begin
            if (!filled[i])
            begin
                send_request(REQ_WRITE, IDX_W'(i), pick_duration(), VAL_W'($urandom), '0);
                made++;
            end
        end
        if (squeeze)
        begin
            squeeze_req <= squeeze_req + 1;
            sender_calm = 1'b1;
        end
        while (made < PHASE_ITEMS)
        begin
            if (squeeze && made >= 30)
                sender_calm = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 62)
                send_bare(REQ_TICK, LOOP_W'($urandom));
            else if (r < 80)
            begin
                idx = ($urandom_range(0, 99) < 70) ? IDX_W'($urandom_range(0, span - 1))
                                                   : IDX_W'($urandom);
                send_request(REQ_WRITE, idx, pick_duration(), VAL_W'($urandom),
                             LOOP_W'($urandom));
            end
            else if (r < 92)
                send_bare(REQ_START, pick_loops());
            else
                send_bare(REQ_STOP, LOOP_W'($urandom));
            made++;
        end
        sender_calm = 1'b0;
    endtask

    // Lengths the phases run at; the tail of the run uses random lengths.
    logic [LEN_W-1:0] plan [8] = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd5, 5'd2, 5'd3};

    initial
    begin
        logic [LEN_W-1:0] len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: three-step table, two loops, through to the final wrap ----
        set_length(LEN_W'(3));
        send_request(REQ_STOP, '0, '0, '0, '0);                  // stop while stopped
        send_request(REQ_WRITE, 4'd0, 16'd1, 16'h8000, '0);      // most negative value
        send_request(REQ_WRITE, 4'd1, 16'd0, 16'h7fff, '0);      // zero duration
        send_request(REQ_WRITE, 4'd2, 16'hffff, 16'hffff, '0);   // longest duration
        send_request(REQ_WRITE, 4'd15, 16'hffff, 16'h7fff, '0);  // top index
        send_request(REQ_START, '0, '0, '0, 16'd2);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_TICK, '0, '0, '0, '0);
        // rewrite the step in use: its new duration applies on the next tick
        send_request(REQ_WRITE, 4'd2, 16'd1, 16'h1234, '0);
        repeat (3) send_request(REQ_TICK, '0, '0, '0, '0);
        // this tick wraps on the last loop: still reports running, then clears
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_TICK, '0, '0, '0, '0);                  // ticks while stopped
        send_request(REQ_START, '0, '0, '0, 16'hffff);
        send_request(REQ_STOP, '0, '0, '0, '0);

        // ---- random phases, one under a long result-side hold-off and one
        // with no idling on either side ----
        for (int p = 0; p < PHASES; p++)
        begin
            len = (p < 8) ? plan[p] : LEN_W'($urandom_range(0, 31));
            rx_calm <= (p == 8);
            run_phase(len, p == 5, p == 8);
        end
        rx_calm <= 1'b0;

        // drain, then wait on to catch any stray result
        settle();
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks, %0d starts, %0d stops, %0d table writes, %0d results.",
                 n_tick, n_start, n_stop, n_write, checked);
        $display("Lengths 0, 1, 16, 17 and 31 among others, one long output hold-off.");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
